### hdl/crc8_packet_framer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-8 packet framer
// Shorthand for clocked assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef CRC8_PACKET_FRAMER_MACROS_SVH
`define CRC8_PACKET_FRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC8PF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC8PF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crc8pf_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 packet framer package
// Shared types, constants and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 3;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned PayloadFields = 4;
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned MaxPayloadDef = 4;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned AddrW         = 3;
  localparam int unsigned DataW         = 32;

  // Register index of the node address (paddr bits above the byte offset).
  localparam logic [AddrW-3:0] RegNodeAddr = '0;

  // CRC-8/Bluetooth computed in reflected form: polynomial 0xA7 bit-reversed.
  localparam logic [ByteW-1:0] CrcPolyRefl = 8'hE5;
  localparam logic [ByteW-1:0] CrcInit     = 8'h00;

  typedef struct packed {
    logic [ByteW-1:0] msg_type;
    logic [LenW-1:0]  payload_len;
    logic [ByteW-1:0] payload_byte_0;
    logic [ByteW-1:0] payload_byte_1;
    logic [ByteW-1:0] payload_byte_2;
    logic [ByteW-1:0] payload_byte_3;
  } req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_byte;
  } resp_t;

  // A classified packet: CRC done, length saturated, ready to serialize.
  typedef struct packed {
    logic [ByteW-1:0]                    crc;
    logic [ByteW-1:0]                    addr;
    logic [LenW-1:0]                     len;
    logic [ByteW-1:0]                    msg_type;
    logic [PayloadFields-1:0][ByteW-1:0] payload;
  } pkt_t;

  // One byte of the reflected CRC: input and output need no bit reversal.
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] acc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = acc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/crc8_packet_framer.sv
// The first byte of a packet is registered in the serializer after the front end's CRC loop
// and the queue. The request rate is set by the serializer, which sends one byte per cycle unless
// out_ready_i holds it off, 4 + len bytes (4 to 8) per packet; the CRC loop is shorter.
// Reset: asynchronous, active low; clears the handshake state, the queue and the node
// address (to 0). No clearing pass is needed.
// ----------------------------------------------------------------------------
// CRC-8 packet framer
// Frames one packet per request: CRC, address, length, type and payload bytes.
// ----------------------------------------------------------------------------
module crc8_packet_framer
  import crc8pf_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output resp_t            out_resp_o
);

  logic [ByteW-1:0] node_address_q;
  logic             sel_node;
  logic             cfg_write;
  logic             push_valid, push_ready;
  pkt_t             push_pkt;
  logic             pop_valid, pop_ready;
  pkt_t             pop_pkt;

  assign pready    = 1'b1;
  assign sel_node  = (paddr[AddrW-1:2] == RegNodeAddr);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = sel_node ? {{(DataW-ByteW){1'b0}}, node_address_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
    end else if (cfg_write && sel_node) begin
      node_address_q <= pwdata[ByteW-1:0];
    end
  end

  crc8pf_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .node_addr_i (node_address_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_pkt_o  (push_pkt)
  );

  crc8pf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_pkt_i  (push_pkt),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_pkt_o   (pop_pkt)
  );

  crc8pf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_pkt_i  (pop_pkt),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_resp_o (out_resp_o)
  );

endmodule

### hdl/crc8pf_front.sv
// ----------------------------------------------------------------------------
// Packet framer front end
// Accepts a request, saturates the length and runs the CRC one byte a cycle.
// ----------------------------------------------------------------------------
`include "crc8_packet_framer_macros.svh"

module crc8pf_front
  import crc8pf_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] node_addr_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output pkt_t             push_pkt_o
);

  localparam int unsigned Limit = (MaxPayload < PayloadFields) ? MaxPayload : PayloadFields;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // Byte positions within the CRC coverage (address is folded in at accept).
  localparam logic [IdxW-1:0] PosLen     = 3'd1;
  localparam logic [IdxW-1:0] PosType    = 3'd2;
  localparam logic [IdxW-1:0] PosPayload = 3'd3;

  logic [1:0]       state_q, state_d;
  pkt_t             pkt_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  last_idx;
  logic [IdxW-1:0]  pay_off;
  logic [ByteW-1:0] byte_sel;
  logic [LenW-1:0]  len_sat;
  logic             accept;
  logic             push;

  assign len_sat = (in_req_i.payload_len > LenW'(Limit)) ? LenW'(Limit)
                                                         : in_req_i.payload_len;

  assign push       = (state_q == StDone) && push_ready_i;
  assign in_ready_o = (state_q == StIdle) || push;
  assign accept     = in_valid_i && in_ready_o;

  assign push_valid_o = (state_q == StDone);
  assign push_pkt_o   = pkt_q;

  assign last_idx = PosType + IdxW'(pkt_q.len);
  assign pay_off  = idx_q - PosPayload;

  always_comb begin
    case (idx_q)
      PosLen:  byte_sel = {{(ByteW-LenW){1'b0}}, pkt_q.len};
      PosType: byte_sel = pkt_q.msg_type;
      default: byte_sel = pkt_q.payload[pay_off[1:0]];
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StCalc;
      end
      StCalc: begin
        if (idx_q == last_idx) state_d = StDone;
      end
      StDone: begin
        if (push) state_d = accept ? StCalc : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pkt_q.crc      <= crc8_byte(CrcInit, node_addr_i);
      pkt_q.addr     <= node_addr_i;
      pkt_q.len      <= len_sat;
      pkt_q.msg_type <= in_req_i.msg_type;
      pkt_q.payload  <= {in_req_i.payload_byte_3, in_req_i.payload_byte_2,
                         in_req_i.payload_byte_1, in_req_i.payload_byte_0};
      idx_q          <= PosLen;
    end else if (state_q == StCalc) begin
      pkt_q.crc <= crc8_byte(pkt_q.crc, byte_sel);
      idx_q     <= idx_q + 3'd1;
    end
  end

  // A finished packet must not change while the queue holds it off.
  `CRC8PF_ASSERT_NEXT(a_done_holds, clk_i, rst_ni, (state_q == StDone) && !push_ready_i, $stable(pkt_q), "front: packet changed while waiting for the queue")

endmodule

### hdl/crc8pf_queue.sv
// ----------------------------------------------------------------------------
// Packet framer queue
// Short FIFO of classified packets between front end and serializer.
// ----------------------------------------------------------------------------
`include "crc8_packet_framer_macros.svh"

module crc8pf_queue
  import crc8pf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  pkt_t push_pkt_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output pkt_t pop_pkt_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_pkt_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_pkt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `CRC8PF_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 1'b1, "queue: fill count did not follow a lone push")

endmodule

### hdl/crc8pf_back.sv
// ----------------------------------------------------------------------------
// Packet framer serializer
// Takes packets from the queue and sends them out one byte per beat.
// ----------------------------------------------------------------------------
`include "crc8_packet_framer_macros.svh"

module crc8pf_back
  import crc8pf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  pkt_t  pop_pkt_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output resp_t out_resp_o
);

  localparam logic [IdxW-1:0] PosCrc     = 3'd0;
  localparam logic [IdxW-1:0] PosAddr    = 3'd1;
  localparam logic [IdxW-1:0] PosLen     = 3'd2;
  localparam logic [IdxW-1:0] PosType    = 3'd3;
  localparam logic [IdxW-1:0] PosPayload = 3'd4;

  logic             have_q;
  pkt_t             pkt_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  resp_t            out_resp_q;
  logic [IdxW-1:0]  last_idx;
  logic [IdxW-1:0]  pay_off;
  logic [ByteW-1:0] byte_sel;
  logic             emit;
  logic             is_last;
  logic             take;

  assign last_idx    = PosType + IdxW'(pkt_q.len);
  assign is_last     = (idx_q == last_idx);
  assign emit        = have_q && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !have_q || (emit && is_last);
  assign take        = pop_valid_i && pop_ready_o;
  assign pay_off     = idx_q - PosPayload;

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

  always_comb begin
    case (idx_q)
      PosCrc:  byte_sel = pkt_q.crc;
      PosAddr: byte_sel = pkt_q.addr;
      PosLen:  byte_sel = {{(ByteW-LenW){1'b0}}, pkt_q.len};
      PosType: byte_sel = pkt_q.msg_type;
      default: byte_sel = pkt_q.payload[pay_off[1:0]];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= PosCrc;
    end else begin
      if (take) begin
        have_q <= 1'b1;
        idx_q  <= PosCrc;
      end else if (emit) begin
        have_q <= !is_last;
        idx_q  <= idx_q + 3'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) pkt_q <= pop_pkt_i;
    if (emit) begin
      out_resp_q.out_byte  <= byte_sel;
      out_resp_q.last_byte <= is_last;
    end
  end

  `CRC8PF_ASSERT_SAME(a_idx_in_range, clk_i, rst_ni, have_q, idx_q <= last_idx, "serializer: byte index ran past the packet end")
  `CRC8PF_ASSERT_NEXT(a_drop_after_last, clk_i, rst_ni, emit && is_last && !pop_valid_i, !have_q, "serializer: still busy after the last byte")

endmodule
